>>> hdl/fas_pkg.sv
`default_nettype none
package fas_pkg;

  localparam int EXP_W  = 8;
  localparam int FRAC_W = 23;
  localparam int MANT_W = FRAC_W + 1;
  localparam int SUM_W  = MANT_W + 1;
  localparam int SH_W   = 5;

  typedef struct packed {
    logic              bypass;
    logic [31:0]       byp_val;
    logic              sbig;
    logic              ssmall;
    logic [EXP_W-1:0]  ebig;
    logic [EXP_W-1:0]  diff;
    logic              eff_sub;
    logic [MANT_W-1:0] m1;
    logic [MANT_W-1:0] m2;
  } s1_t;

  typedef struct packed {
    logic              bypass;
    logic [31:0]       byp_val;
    logic              sbig;
    logic              ssmall;
    logic [EXP_W-1:0]  ebig;
    logic              negate;
    logic [SUM_W-1:0]  sum;
  } s2_t;

  typedef struct packed {
    logic              bypass;
    logic [31:0]       byp_val;
    logic              sign;
    logic [EXP_W-1:0]  exp;
    logic [MANT_W-1:0] mag;
    logic [SH_W-1:0]   shamt;
  } s3_t;

endpackage
`default_nettype wire

>>> hdl/float32_add_sub_truncating_top.sv
// Single-precision adder/subtractor with truncation, no rounding and no
// infinity or NaN handling.
// Input channel: in_valid/in_ready with in_op (0 add, 1 subtract b from a),
// in_operand_a and in_operand_b as raw bit patterns.
// Result channel: out_valid/out_ready with out_sum_bits.
// Throughput: one item per cycle unless the receiver stalls; four pipeline
// stages (swap and align prep, shift and add, fix-up and leading-zero
// count, normalise shift).
// A zero operand passes the other (-b on subtract) through the same stages.
// Reset clears all stage valid bits; data registers are not reset.
// When the receiver stalls, the whole pipeline holds and in_ready falls;
// nothing is lost or repeated. in_ready depends on out_ready in the same
// cycle.
`default_nettype none
module float32_add_sub_truncating_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_op,
  input  wire logic [31:0] in_operand_a,
  input  wire logic [31:0] in_operand_b,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_sum_bits
);
  import fas_pkg::*;

  logic adv;
  logic v1_r, v2_r, v3_r, v4_r;
  s1_t  s1;
  s2_t  s2;

  assign adv       = !v4_r || out_ready;
  assign in_ready  = adv;
  assign out_valid = v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  fas_align u_align (
    .clk       (clk),
    .en        (adv),
    .op        (in_op),
    .operand_a (in_operand_a),
    .operand_b (in_operand_b),
    .s1_r      (s1)
  );

  fas_addsub u_addsub (
    .clk  (clk),
    .en   (adv),
    .s1   (s1),
    .s2_r (s2)
  );

  fas_norm u_norm (
    .clk   (clk),
    .en    (adv),
    .s2    (s2),
    .res_r (out_sum_bits)
  );

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v1_r)
    else $error("transfer did not enter stage one");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(v1_r) && $stable(v2_r) && $stable(v3_r)))
    else $error("pipeline moved during stall");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !v3_r) |=> !out_valid)
    else $error("result repeated after transfer");

endmodule
`default_nettype wire

>>> hdl/fas_align.sv
`default_nettype none
module fas_align (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic               op,
  input  wire logic [31:0]        operand_a,
  input  wire logic [31:0]        operand_b,
  output fas_pkg::s1_t            s1_r
);
  import fas_pkg::*;

  s1_t              s1_nxt;
  logic [EXP_W-1:0] ea, eb;
  logic             sa, sb;
  logic             swap;

  always_comb begin
    ea   = operand_a[30:23];
    eb   = operand_b[30:23];
    sa   = operand_a[31];
    sb   = operand_b[31] ^ op;
    swap = ea < eb;
    s1_nxt.bypass  = (operand_a[30:0] == 31'd0) || (operand_b[30:0] == 31'd0);
    s1_nxt.byp_val = (operand_a[30:0] == 31'd0) ? (operand_b ^ {op, 31'd0}) : operand_a;
    s1_nxt.sbig    = swap ? sb : sa;
    s1_nxt.ssmall  = swap ? sa : sb;
    s1_nxt.ebig    = swap ? eb : ea;
    s1_nxt.diff    = swap ? (eb - ea) : (ea - eb);
    s1_nxt.eff_sub = sa != sb;
    s1_nxt.m1      = {1'b1, swap ? operand_b[22:0] : operand_a[22:0]};
    s1_nxt.m2      = {1'b1, swap ? operand_a[22:0] : operand_b[22:0]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hdl/fas_addsub.sv
`default_nettype none
module fas_addsub (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire fas_pkg::s1_t       s1,
  output fas_pkg::s2_t            s2_r
);
  import fas_pkg::*;

  s2_t                     s2_nxt;
  logic signed [SUM_W:0]   m2n;
  logic signed [SUM_W:0]   m2s;
  logic        [SUM_W:0]   sum;
  logic        [SH_W-1:0]  sh;

  always_comb begin
    m2n = s1.eff_sub ? -$signed({2'b00, s1.m2}) : $signed({2'b00, s1.m2});
    sh  = (s1.diff[EXP_W-1:SH_W] != '0) ? '1 : s1.diff[SH_W-1:0];
    m2s = m2n >>> sh;
    sum = {2'b00, s1.m1} + m2s;
    s2_nxt.bypass  = s1.bypass;
    s2_nxt.byp_val = s1.byp_val;
    s2_nxt.sbig    = s1.sbig;
    s2_nxt.ssmall  = s1.ssmall;
    s2_nxt.ebig    = s1.ebig;
    s2_nxt.sum     = sum[SUM_W-1:0];
    s2_nxt.negate  = s1.eff_sub && (s1.diff == '0) && sum[MANT_W] && sum[MANT_W-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r <= s2_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hdl/fas_norm.sv
`default_nettype none
module fas_norm (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire fas_pkg::s2_t       s2,
  output logic [31:0]             res_r
);
  import fas_pkg::*;

  s3_t              s3_r, s3_nxt;
  logic [31:0]      res_nxt;
  logic [SUM_W-1:0] sumn;
  logic [SH_W-1:0]  lz;
  logic [MANT_W-1:0] shifted;
  logic [EXP_W-1:0] exp_out;

  always_comb begin
    sumn = s2.negate ? (~s2.sum + 1'b1) : s2.sum;
    lz   = SH_W'(MANT_W);
    for (int i = 0; i < MANT_W; i++) begin
      if (sumn[i]) lz = SH_W'(MANT_W - 1 - i);
    end
    s3_nxt.bypass  = s2.bypass;
    s3_nxt.byp_val = s2.byp_val;
    s3_nxt.sign    = s2.negate ? s2.ssmall : s2.sbig;
    if (sumn[MANT_W]) begin
      s3_nxt.exp   = s2.ebig + 1'b1;
      s3_nxt.mag   = sumn[MANT_W:1];
      s3_nxt.shamt = '0;
    end else if (sumn[MANT_W-1:0] == '0) begin
      s3_nxt.exp   = '0;
      s3_nxt.mag   = '0;
      s3_nxt.shamt = '0;
    end else begin
      s3_nxt.exp   = s2.ebig;
      s3_nxt.mag   = sumn[MANT_W-1:0];
      s3_nxt.shamt = ({3'b000, lz} < s2.ebig) ? lz : s2.ebig[SH_W-1:0];
    end
  end

  always_comb begin
    shifted = s3_r.mag << s3_r.shamt;
    exp_out = s3_r.exp - {3'b000, s3_r.shamt};
    res_nxt = s3_r.bypass ? s3_r.byp_val : {s3_r.sign, exp_out, shifted[FRAC_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r  <= s3_nxt;
      res_r <= res_nxt;
    end
  end

endmodule
`default_nettype wire
